// ===== rtl/cdvr_pkg.sv =====
// shared types and constants for the coordinated distance-vector router
// no dependencies
package cdvr_pkg;

  localparam logic [2:0] K_ROUTE   = 3'd0;
  localparam logic [2:0] K_COORD   = 3'd1;
  localparam logic [2:0] K_UNCOORD = 3'd2;
  localparam logic [2:0] K_CHAT    = 3'd3;
  localparam logic [2:0] K_JOIN    = 3'd4;
  localparam logic [2:0] K_DELIVER = 3'd4;

  localparam logic [7:0] DIST_INF = 8'd255;
  localparam logic [5:0] NO_NODE  = 6'd63;
  localparam logic [6:0] PEND_MAX = 7'd127;

  typedef struct packed {
    logic [7:0] hops;
    logic [5:0] succ;
    logic       coord;
    logic [5:0] parent;
    logic [6:0] pend;
  } entry_t;

  localparam entry_t ENT_RST = '{hops: DIST_INF, succ: NO_NODE, coord: 1'b0,
                                 parent: NO_NODE, pend: 7'd0};

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] to;
    logic [4:0] dest;
    logic [7:0] hop;
  } msg_t;

  typedef struct packed {
    logic put;
    logic flush;
  } emit_ctl_t;

endpackage

// ===== rtl/cdvr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module cdvr_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cdvr_emit.sv =====
// result stage: holds one message back so the final one can carry tlast,
// then an output register; depends on cdvr_pkg
module cdvr_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  cdvr_pkg::emit_ctl_t ctl,
  input  cdvr_pkg::msg_t    msg,
  output logic              ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,   // to_node, about_dest, hop_distance, zero pad
  output logic [2:0]        out_tuser,   // send_kind
  output logic              out_tlast
);

  cdvr_pkg::msg_t hold_r, out_msg_r;
  logic           hold_v_r, out_valid_r, out_last_r;
  logic           push;

  assign ready = !out_valid_r || out_tready;
  assign push  = ready && hold_v_r && (ctl.put || ctl.flush);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ready) begin
      out_valid_r <= push;
      if (ctl.put) begin
        hold_v_r <= 1'b1;
      end else if (ctl.flush) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && ctl.put) begin
      hold_r <= msg;
    end
    if (push) begin
      out_msg_r  <= hold_r;
      out_last_r <= ctl.flush && !ctl.put;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_msg_r.kind;
  assign out_tdata  = {3'd0, out_msg_r.hop, out_msg_r.dest, out_msg_r.to};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/coordinated_distance_vector_router.sv =====
// top level: event sequencer around the per-destination route table ram
// depends on cdvr_pkg, cdvr_ram, cdvr_emit
//
// Usage:
// - in_* takes one decoded event per beat: tuser = kind, tdata = target_dest,
//   advertised_distance, from_neighbor. out_* gives the messages to send,
//   tlast on the final message of an event; an event may produce none.
// - cfg_we/cfg_wdata write own_node_id; write only while the block is idle.
// - one event at a time: in_tready is high only while idle. A route,
//   coordinate, uncoordinate or chat event steps through accept, table
//   read, update and finish, plus a scan of min(NODES,32) neighbor slots
//   when it broadcasts and a step for a trailing message.
//   A neighbor join walks every destination entry, one ram read per cycle
//   while out_tready does not stall. The ram read port sets this pace.
// - each message sits in a hold register until the next message or the
//   finish of the event, so tlast can be known.
// - a stalled out_tready freezes the sequencer; nothing is dropped.
// - after reset all routes are infinite, no neighbors are known; table
//   entries never written read as their reset values through valid bits.
module coordinated_distance_vector_router #(
  parameter int NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // target_dest, advertised_distance, from_neighbor, zero pad
  input  logic [2:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // to_node, about_dest, hop_distance, zero pad
  output logic [2:0]  out_tuser,  // send_kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  localparam int         LIM     = (NODES < 32) ? NODES : 32;
  localparam logic [4:0] LIM_M1  = 5'(LIM - 1);
  localparam logic [5:0] NODES_W = 6'(NODES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_BCAST = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [2:0] ST_JWALK = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [4:0]  d_r, d_nxt;
  logic [7:0]  advd_r, advd_nxt;
  logic [4:0]  from_r, from_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [7:0]  hopb_r, hopb_nxt;
  logic [2:0]  bkind_r, bkind_nxt;
  logic        tail_v_r, tail_v_nxt;
  logic [4:0]  tail_to_r, tail_to_nxt;
  logic        bcast_v;
  logic [4:0]  own_r;
  logic [31:0] present_r, present_nxt;
  logic [31:0] vld_r;
  logic [4:0]  rq_r, raddr;
  cdvr_pkg::entry_t ent_r, ent_nxt, ram_rd, rd_ent;
  logic        ram_we;
  logic        step;
  logic [7:0]  dd, nd, jd;
  logic [6:0]  pn;
  cdvr_pkg::emit_ctl_t ctl;
  cdvr_pkg::msg_t      msg;

  logic [4:0] in_d, in_from;
  logic [7:0] in_adv;
  assign in_d    = in_tdata[4:0];
  assign in_adv  = in_tdata[12:5];
  assign in_from = in_tdata[17:13];

  assign in_tready = (state_r == ST_IDLE);
  assign rd_ent    = vld_r[rq_r] ? ram_rd : cdvr_pkg::ENT_RST;

  cdvr_ram #(.W($bits(cdvr_pkg::entry_t)), .DEPTH(32)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (d_r),
    .wdata (ent_r),
    .raddr (raddr),
    .rdata (ram_rd)
  );

  cdvr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .msg        (msg),
    .ready      (step),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    d_nxt       = d_r;
    advd_nxt    = advd_r;
    from_nxt    = from_r;
    idx_nxt     = idx_r;
    hopb_nxt    = hopb_r;
    bkind_nxt   = bkind_r;
    tail_v_nxt  = tail_v_r;
    tail_to_nxt = tail_to_r;
    present_nxt = present_r;
    ent_nxt     = ent_r;
    ram_we      = 1'b0;
    ctl         = '0;
    msg         = '0;
    raddr       = d_r;
    bcast_v     = 1'b0;
    dd          = (d_r == own_r) ? 8'd0 : rd_ent.hops;
    nd          = (advd_r == cdvr_pkg::DIST_INF) ? cdvr_pkg::DIST_INF : advd_r + 8'd1;
    pn          = (rd_ent.pend != 7'd0) ? rd_ent.pend - 7'd1 : 7'd0;
    jd          = (idx_r == own_r) ? 8'd0 : rd_ent.hops;

    case (state_r)
      ST_IDLE: begin
        raddr = in_d;
        if (in_tvalid) begin
          kind_nxt   = in_tuser;
          d_nxt      = in_d;
          advd_nxt   = in_adv;
          from_nxt   = in_from;
          tail_v_nxt = 1'b0;
          idx_nxt    = 5'd0;
          if (in_tuser > cdvr_pkg::K_JOIN || {1'b0, in_from} >= NODES_W) begin
            state_nxt = ST_IDLE;
          end else if (in_tuser == cdvr_pkg::K_JOIN) begin
            present_nxt[in_from] = 1'b1;
            raddr     = 5'd0;
            state_nxt = ST_JWALK;
          end else if ({1'b0, in_d} < NODES_W) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (step) begin
          ent_nxt = rd_ent;
          case (kind_r)
            cdvr_pkg::K_ROUTE: begin
              if (d_r != own_r && (nd < rd_ent.hops || {1'b0, from_r} == rd_ent.succ)) begin
                ent_nxt.hops = nd;
                ent_nxt.succ = {1'b0, from_r};
                if (!rd_ent.coord) begin
                  bcast_v   = 1'b1;
                  bkind_nxt = cdvr_pkg::K_ROUTE;
                  hopb_nxt  = nd;
                end
              end
            end
            cdvr_pkg::K_COORD: begin
              if (rd_ent.coord) begin
                ctl.put = 1'b1;
                msg     = '{kind: cdvr_pkg::K_UNCOORD, to: from_r, dest: d_r, hop: 8'd0};
              end else if (rd_ent.succ == {1'b0, from_r}) begin
                ent_nxt.hops   = cdvr_pkg::DIST_INF;
                ent_nxt.succ   = cdvr_pkg::NO_NODE;
                ent_nxt.coord  = 1'b1;
                ent_nxt.parent = {1'b0, from_r};
                bcast_v   = 1'b1;
                bkind_nxt = cdvr_pkg::K_COORD;
                hopb_nxt  = 8'd0;
              end else begin
                ctl.put     = 1'b1;
                msg         = '{kind: cdvr_pkg::K_ROUTE, to: from_r, dest: d_r, hop: dd};
                tail_v_nxt  = 1'b1;
                tail_to_nxt = from_r;
              end
            end
            cdvr_pkg::K_UNCOORD: begin
              ent_nxt.pend = pn;
              if (pn == 7'd0) begin
                ent_nxt.coord = 1'b0;
                if (dd != cdvr_pkg::DIST_INF) begin
                  bcast_v   = 1'b1;
                  bkind_nxt = cdvr_pkg::K_ROUTE;
                  hopb_nxt  = dd;
                end
                if (rd_ent.parent != cdvr_pkg::NO_NODE) begin
                  tail_v_nxt     = 1'b1;
                  tail_to_nxt    = rd_ent.parent[4:0];
                  ent_nxt.parent = cdvr_pkg::NO_NODE;
                end
              end
            end
            cdvr_pkg::K_CHAT: begin
              if (d_r == own_r) begin
                ctl.put = 1'b1;
                msg     = '{kind: cdvr_pkg::K_DELIVER, to: own_r, dest: d_r, hop: 8'd0};
              end else if (!rd_ent.coord && rd_ent.succ != cdvr_pkg::NO_NODE) begin
                ctl.put = 1'b1;
                msg     = '{kind: cdvr_pkg::K_CHAT, to: rd_ent.succ[4:0], dest: d_r,
                            hop: 8'd0};
              end
            end
            default: begin
            end
          endcase
          idx_nxt = 5'd0;
          if (bcast_v) begin
            state_nxt = ST_BCAST;
          end else if (tail_v_nxt) begin
            state_nxt = ST_TAIL;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_BCAST: begin
        if (step) begin
          if (present_r[idx_r] && idx_r != own_r) begin
            ctl.put = 1'b1;
            msg     = '{kind: bkind_r, to: idx_r, dest: d_r, hop: hopb_r};
            if (bkind_r == cdvr_pkg::K_COORD && ent_r.pend < cdvr_pkg::PEND_MAX) begin
              ent_nxt.pend = ent_r.pend + 7'd1;
            end
          end
          if (idx_r == LIM_M1) begin
            state_nxt = tail_v_r ? ST_TAIL : ST_FIN;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      ST_TAIL: begin
        if (step) begin
          ctl.put   = 1'b1;
          msg       = '{kind: cdvr_pkg::K_UNCOORD, to: tail_to_r, dest: d_r, hop: 8'd0};
          state_nxt = ST_FIN;
        end
      end
      ST_JWALK: begin
        // rd_ent always belongs to idx_r here; the address only moves on a step
        raddr = step ? idx_r + 5'd1 : idx_r;
        if (step) begin
          if (jd != cdvr_pkg::DIST_INF && !rd_ent.coord) begin
            ctl.put = 1'b1;
            msg     = '{kind: cdvr_pkg::K_ROUTE, to: from_r, dest: idx_r, hop: jd};
          end
          if (idx_r == LIM_M1) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      ST_FIN: begin
        if (step) begin
          ctl.flush = 1'b1;
          ram_we    = (kind_r != cdvr_pkg::K_JOIN);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      own_r     <= 5'd0;
      present_r <= '0;
      vld_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      present_r <= present_nxt;
      if (cfg_we) begin
        own_r <= cfg_wdata;
      end
      if (ram_we) begin
        vld_r[d_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    d_r       <= d_nxt;
    advd_r    <= advd_nxt;
    from_r    <= from_nxt;
    idx_r     <= idx_nxt;
    hopb_r    <= hopb_nxt;
    bkind_r   <= bkind_nxt;
    tail_v_r  <= tail_v_nxt;
    tail_to_r <= tail_to_nxt;
    ent_r     <= ent_nxt;
    rq_r      <= raddr;
  end

`ifndef SYNTHESIS
  a_bad_kind_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser > cdvr_pkg::K_JOIN) |=> state_r == ST_IDLE)
    else $error("unknown event kind was not ignored");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BCAST || state_r == ST_JWALK) |-> idx_r <= LIM_M1)
    else $error("walk index beyond node limit");

  a_fin_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && step) |=> (state_r == ST_IDLE && !out_tvalid) || out_tlast)
    else $error("event finished without final beat");
`endif

endmodule
